FILE: sv/adrc_pkg.sv
package adrc_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int DB_FRAC_BITS    = 8;
  localparam int TABLE_ADDR_BITS = 8;
  localparam int TSIZE           = 1 << TABLE_ADDR_BITS;

  localparam int DB_W     = 16;   // threshold and gain in dB
  localparam int STATE_W  = 24;   // smoothed gain state
  localparam int INV_W    = 17;
  localparam int COEFF_W  = 16;
  localparam int Q16_W    = 17;   // values up to and including 1.0 in Q16
  localparam int DEPTH_W  = $clog2(SAMPLE_WIDTH) + 16;
  localparam int POS_W    = $clog2(SAMPLE_WIDTH);
  localparam int MUL_W    = 25;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int WORK_W   = 18;   // level, difference and gain change

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INV_RATIO = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH    = CFG_IDX_W'(2);

  localparam logic signed [DB_W-1:0] THRESHOLD_RST = -16'sd5120;
  localparam logic [INV_W-1:0]       INV_RST       = 17'd16384;
  localparam logic [COEFF_W-1:0]     SMOOTH_RST    = 16'd65000;

  localparam int DB_PER_OCT_Q16 = 394566;
  localparam int OCT_PER_DB_Q24 = 2786635;
  localparam int FLOOR_DB       = -(96 << DB_FRAC_BITS);
  localparam int UNITY_Q16      = 65536;

  typedef logic [15:0]      log_tab_t [TSIZE];
  typedef logic [Q16_W-1:0] exp_tab_t [TSIZE];

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_op_t;

  // log2(x/65536) in Q16, x in [65536, 131072), by repeated squaring
  function automatic logic [15:0] log2_frac(input logic [16:0] x);
    logic [63:0] v;
    logic [15:0] r;
    v = 64'(x) << 14;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      v = (v * v) >> 30;
      r = {r[14:0], 1'b0};
      if (v >= 64'h8000_0000) begin
        r[0] = 1'b1;
        v    = v >> 1;
      end
    end
    return r;
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t t;
    for (int i = 0; i < TSIZE; i++) begin
      t[i] = log2_frac(17'(65536 + (i << (16 - TABLE_ADDR_BITS))));
    end
    return t;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t t;
    int lo, hi, mid, target;
    for (int i = 0; i < TSIZE; i++) begin
      if (i == 0) begin
        t[i] = Q16_W'(UNITY_Q16);
      end else begin
        target = 65536 - (i << (16 - TABLE_ADDR_BITS));
        lo = 65536;
        hi = 131071;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          if (int'(log2_frac(17'(mid))) <= target) lo = mid;
          else hi = mid - 1;
        end
        t[i] = Q16_W'((lo + 1) >> 1);
      end
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();
  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

FILE: sv/audio_dynamic_range_compressor_top.sv
// Log-domain feed-forward compressor. One sample is taken when in_ready is
// high and its result is registered at the end of the sequence; in_ready
// returns together with out_valid, so no new sample is taken until the last
// one is finished. If the previous result is still waiting, the sequencer holds
// in its last step until the receiver takes it. Every multiply (level, gain
// computer, two smoothing terms, make-up, dB to linear, output scaling) goes
// through one registered 25x25 multiplier. Configuration writes are taken only
// while idle (cfg_ready low during an item) and act on the next item.
module audio_dynamic_range_compressor_top (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [adrc_pkg::SAMPLE_WIDTH-1:0]  in_sample_in,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [adrc_pkg::SAMPLE_WIDTH-1:0]  out_sample_out,
  output logic signed [adrc_pkg::DB_W-1:0]          out_gain_change_db,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [adrc_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [adrc_pkg::CFG_DATA_W-1:0]           cfg_data
);

  localparam int SW  = adrc_pkg::SAMPLE_WIDTH;
  localparam int F   = adrc_pkg::DB_FRAC_BITS;
  localparam int T   = adrc_pkg::TABLE_ADDR_BITS;
  localparam int PW  = adrc_pkg::PROD_W;
  localparam int MW  = adrc_pkg::MUL_W;
  localparam int WW  = adrc_pkg::WORK_W;
  localparam int YW  = adrc_pkg::STATE_W;
  localparam int DW  = adrc_pkg::DB_W;
  localparam int QW  = adrc_pkg::Q16_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LVL, S_LVL2, S_GAIN, S_GAIN2, S_SMA, S_SMB, S_SMY,
    S_MK, S_EXP, S_EXP2, S_OUT, S_OUT2
  } state_t;

  state_t state_r;

  logic signed [DW-1:0]             thr_r;
  logic [adrc_pkg::INV_W-1:0]       inv_r;
  logic [adrc_pkg::COEFF_W-1:0]     coeff_r;
  logic signed [YW-1:0]             y_r;
  logic signed [SW-1:0]             s_r;
  logic [adrc_pkg::DEPTH_W-1:0]     depth_r;
  logic                             zero_r;
  logic signed [WW-1:0]             level_r;
  logic signed [WW-1:0]             g_r;
  logic signed [PW-1:0]             acc_r;
  logic signed [DW-1:0]             tot_r;
  logic [QW-1:0]                    gl_r;
  logic                             out_valid_r;
  logic signed [SW-1:0]             out_sample_r;
  logic signed [DW-1:0]             out_gain_r;

  logic [adrc_pkg::DEPTH_W-1:0]     depth_c;
  logic                             zero_c;
  adrc_pkg::mul_op_t                mul_op;
  logic signed [PW-1:0]             prod;

  logic [QW-1:0]                    inv_sat;
  logic [QW-1:0]                    coeff_cmp;
  logic signed [WW-1:0]             thr_x;
  logic signed [WW-1:0]             diff;
  logic signed [PW-1:0]             t_p;
  logic signed [WW-1:0]             level_c;
  logic signed [WW-1:0]             g_c;
  logic signed [PW-1:0]             y_p;
  logic signed [YW-1:0]             y_c;
  logic signed [YW+1:0]             tot_p;
  logic signed [DW-1:0]             tot_c;
  logic [PW-1:0]                    e_p;
  logic [QW-1:0]                    gl_c;
  logic signed [SW-1:0]             o_c;

  adrc_log u_log (
    .sample (in_sample_in),
    .depth  (depth_c),
    .zero   (zero_c)
  );

  adrc_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  assign inv_sat   = (inv_r > QW'(adrc_pkg::UNITY_Q16)) ? QW'(adrc_pkg::UNITY_Q16) : inv_r;
  assign coeff_cmp = QW'(adrc_pkg::UNITY_Q16) - QW'(coeff_r);
  assign thr_x     = WW'(thr_r);
  assign diff      = level_r - thr_x;

  // operand selection for the shared multiplier
  always_comb begin
    mul_op = '0;
    unique case (state_r)
      S_LVL: begin
        mul_op.a = MW'(depth_r);
        mul_op.b = MW'(adrc_pkg::DB_PER_OCT_Q16);
      end
      S_GAIN: begin
        mul_op.a = MW'(diff);
        mul_op.b = MW'(inv_sat);
      end
      S_SMA: begin
        mul_op.a = MW'(y_r);
        mul_op.b = MW'(coeff_r);
      end
      S_SMB: begin
        mul_op.a = MW'(g_r);
        mul_op.b = MW'(coeff_cmp);
      end
      S_SMY: begin
        mul_op.a = MW'(-thr_x);
        mul_op.b = MW'(QW'(adrc_pkg::UNITY_Q16) - inv_sat);
      end
      S_EXP: begin
        mul_op.a = MW'(-WW'(tot_r));
        mul_op.b = MW'(adrc_pkg::OCT_PER_DB_Q24);
      end
      // held through an output stall so the product stays put
      S_OUT, S_OUT2: begin
        mul_op.a = MW'(s_r);
        mul_op.b = MW'(gl_r);
      end
      default: mul_op = '0;
    endcase
  end

  always_comb begin
    // level in dB from depth product
    t_p = (prod + PW'(64'd1 << (31 - F))) >>> (32 - F);
    if (zero_r || -WW'(t_p) < WW'(adrc_pkg::FLOOR_DB)) level_c = WW'(adrc_pkg::FLOOR_DB);
    else level_c = -WW'(t_p);

    // gain computer: g = computed level minus input level
    if (level_r > thr_x) g_c = thr_x + WW'((prod + PW'(32768)) >>> 16) - level_r;
    else g_c = '0;

    // one-pole smoothing, saturated to the state width
    y_p = (acc_r + prod + PW'(32768)) >>> 16;
    if (y_p > PW'((1 << (YW - 1)) - 1)) y_c = {1'b0, {(YW-1){1'b1}}};
    else if (y_p < -PW'(1 << (YW - 1))) y_c = {1'b1, {(YW-1){1'b0}}};
    else y_c = YW'(y_p);

    // make-up gain added, total clamped to [floor, 0 dB]
    tot_p = (YW+2)'(y_r) + (YW+2)'((prod + PW'(32768)) >>> 16);
    if (tot_p > 0) tot_c = '0;
    else if (tot_p < (YW+2)'(adrc_pkg::FLOOR_DB)) tot_c = DW'(adrc_pkg::FLOOR_DB);
    else tot_c = DW'(tot_p);

    // attenuation in octaves Q16 to linear gain
    e_p = PW'(unsigned'(prod) + PW'(64'd1 << (F + 7))) >> (F + 8);
    if (e_p[PW-1:16] >= (PW-16)'(17)) gl_c = '0;
    else gl_c = adrc_pkg::EXP_TAB[e_p[15:16-T]] >> e_p[20:16];

    // output scaling with saturation
    t_p = (prod + PW'(32768)) >>> 16;
    if (t_p > PW'((1 << (SW - 1)) - 1)) o_c = {1'b0, {(SW-1){1'b1}}};
    else if (t_p < -PW'(1 << (SW - 1))) o_c = {1'b1, {(SW-1){1'b0}}};
    else o_c = SW'(t_p);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= adrc_pkg::THRESHOLD_RST;
      inv_r       <= adrc_pkg::INV_RST;
      coeff_r     <= adrc_pkg::SMOOTH_RST;
      y_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          adrc_pkg::REG_THRESHOLD: thr_r   <= cfg_data[DW-1:0];
          adrc_pkg::REG_INV_RATIO: inv_r   <= cfg_data[adrc_pkg::INV_W-1:0];
          adrc_pkg::REG_SMOOTH:    coeff_r <= cfg_data[adrc_pkg::COEFF_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_OUT2 && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            s_r     <= in_sample_in;
            depth_r <= depth_c;
            zero_r  <= zero_c;
            state_r <= S_LVL;
          end
        end
        S_LVL:  state_r <= S_LVL2;
        S_LVL2: begin
          level_r <= level_c;
          state_r <= S_GAIN;
        end
        S_GAIN: state_r <= S_GAIN2;
        S_GAIN2: begin
          g_r     <= g_c;
          state_r <= S_SMA;
        end
        S_SMA:  state_r <= S_SMB;
        S_SMB: begin
          acc_r   <= prod;
          state_r <= S_SMY;
        end
        S_SMY: begin
          y_r     <= y_c;
          state_r <= S_MK;
        end
        S_MK: begin
          tot_r   <= tot_c;
          state_r <= S_EXP;
        end
        S_EXP:  state_r <= S_EXP2;
        S_EXP2: begin
          gl_r    <= gl_c;
          state_r <= S_OUT;
        end
        S_OUT:  state_r <= S_OUT2;
        S_OUT2: begin
          if (!out_valid_r || out_ready) begin
            out_sample_r <= o_c;
            out_gain_r   <= tot_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready           = (state_r == S_IDLE);
  assign cfg_ready          = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_sample_out     = out_sample_r;
  assign out_gain_change_db = out_gain_r;

endmodule

FILE: sv/adrc_mul.sv
// Shared signed multiplier, product registered
module adrc_mul (
  input  logic                                  clk,
  input  adrc_pkg::mul_op_t                     op,
  output logic signed [adrc_pkg::PROD_W-1:0]    prod
);

  logic signed [adrc_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op.a * op.b;
  end

  assign prod = prod_r;

endmodule

FILE: sv/adrc_log.sv
// Magnitude to depth below full scale in log2 units, Q16
module adrc_log (
  input  logic signed [adrc_pkg::SAMPLE_WIDTH-1:0] sample,
  output logic [adrc_pkg::DEPTH_W-1:0]             depth,
  output logic                                     zero
);

  localparam int SW = adrc_pkg::SAMPLE_WIDTH;
  localparam int T  = adrc_pkg::TABLE_ADDR_BITS;

  logic [SW-1:0]                 mag;
  logic [adrc_pkg::POS_W-1:0]    pos;
  logic [SW+T-1:0]               shifted;
  logic [T-1:0]                  idx;
  logic [adrc_pkg::DEPTH_W-1:0]  l2;

  always_comb begin
    mag = sample[SW-1] ? SW'(-sample) : SW'(sample);
    pos = '0;
    for (int i = 0; i < SW; i++) begin
      if (mag[i]) pos = adrc_pkg::POS_W'(i);
    end
    shifted = {mag, {T{1'b0}}} >> pos;
    idx     = shifted[T-1:0];
    l2      = {pos, 16'd0} + adrc_pkg::DEPTH_W'(adrc_pkg::LOG_TAB[idx]);
    depth   = adrc_pkg::DEPTH_W'((SW - 1) << 16) - l2;
    zero    = (mag == '0);
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int SW = adrc_pkg::SAMPLE_WIDTH;
  localparam int F  = adrc_pkg::DB_FRAC_BITS;
  localparam int T  = adrc_pkg::TABLE_ADDR_BITS;
  localparam int TS = adrc_pkg::TSIZE;
  localparam int QW = adrc_pkg::Q16_W;
  localparam int DBW = adrc_pkg::DB_W;
  localparam int CIW = adrc_pkg::CFG_IDX_W;
  localparam int CDW = adrc_pkg::CFG_DATA_W;
  localparam longint FLOOR_Q = -(longint'(96) << F);
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [SW-1:0] in_sample_in;
  logic out_valid;
  logic out_ready;
  logic signed [SW-1:0] out_sample_out;
  logic signed [DBW-1:0] out_gain_change_db;
  logic cfg_valid;
  logic cfg_ready;
  logic [CIW-1:0] cfg_index;
  logic [CDW-1:0] cfg_data;

  audio_dynamic_range_compressor_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample_in(in_sample_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sample_out(out_sample_out), .out_gain_change_db(out_gain_change_db),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    logic signed [SW-1:0]  sample;
    logic signed [DBW-1:0] gain;
  } comp_result_t;

  comp_result_t pending_q[$];
  int  failures;
  int  cycle_count;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  recv_hold;
  int  hold_reqs;
  int  holds_taken;

  // predictor state
  longint thr_q;
  longint inv_q;
  longint coeff_q;
  longint env_q;
  logic [15:0]   lg_tab [TS];
  logic [QW-1:0] ex_tab [TS];

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [15:0] frac_log2(longint x);
    longint unsigned v;
    logic [15:0] r;
    v = longint'(x) << 14;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      v = (v * v) >> 30;
      r = {r[14:0], 1'b0};
      if (v >= 64'h8000_0000) begin
        r[0] = 1'b1;
        v = v >> 1;
      end
    end
    return r;
  endfunction

  task automatic fill_tables();
    longint lo, hi, mid, target;
    for (int i = 0; i < TS; i++) begin
      lg_tab[i] = frac_log2(65536 + (i << (16 - T)));
      if (i == 0) begin
        ex_tab[i] = QW'(65536);
      end else begin
        target = 65536 - (i << (16 - T));
        lo = 65536;
        hi = 131071;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          if (longint'(frac_log2(mid)) <= target) lo = mid;
          else hi = mid - 1;
        end
        ex_tab[i] = QW'((lo + 1) >> 1);
      end
    end
  endtask

  function automatic comp_result_t compress_sample(logic signed [SW-1:0] smp);
    comp_result_t r;
    longint s, m, level, inv, outl, g, y, mk, tot, o, smax;
    longint unsigned idx, l2, depth, e, ip, gl;
    int p;
    s = smp;
    m = s < 0 ? -s : s;
    smax = (longint'(1) << (SW - 1)) - 1;
    if (m == 0) begin
      level = FLOOR_Q;
    end else begin
      p = 0;
      while (p < 63 && (m >> (p + 1)) != 0) p++;
      if (p >= T) idx = (m >> (p - T)) & (TS - 1);
      else idx = (m << (T - p)) & (TS - 1);
      l2 = (longint'(p) << 16) + lg_tab[idx];
      depth = (longint'(SW - 1) << 16) - l2;
      level = -longint'((depth * adrc_pkg::DB_PER_OCT_Q16 + (longint'(1) << (31 - F)))
                        >> (32 - F));
      if (level < FLOOR_Q) level = FLOOR_Q;
    end
    inv = inv_q > 65536 ? 65536 : inv_q;
    if (level > thr_q) outl = thr_q + shr_floor((level - thr_q) * inv + 32768, 16);
    else outl = level;
    g = outl - level;
    y = shr_floor(coeff_q * env_q + (65536 - coeff_q) * g + 32768, 16);
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    env_q = y;
    mk = shr_floor(-thr_q * (65536 - inv) + 32768, 16);
    tot = y + mk;
    if (tot > 0) tot = 0;
    if (tot < FLOOR_Q) tot = FLOOR_Q;
    e = (longint'(-tot) * adrc_pkg::OCT_PER_DB_Q24 + (longint'(1) << (F + 7))) >> (F + 8);
    ip = e >> 16;
    if (ip >= 17) gl = 0;
    else gl = longint'(ex_tab[(e & 16'hFFFF) >> (16 - T)]) >> ip;
    o = shr_floor(s * longint'(gl) + 32768, 16);
    if (o > smax) o = smax;
    if (o < -smax - 1) o = -smax - 1;
    r.sample = SW'(o);
    r.gain = DBW'(tot);
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ready <= 1'b0;
    end else if (holds_taken != hold_reqs) begin
      holds_taken <= holds_taken + 1;
      recv_hold <= 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    comp_result_t x;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("result item with nothing expected");
        failures++;
      end else begin
        x = pending_q.pop_front();
        if (out_sample_out !== x.sample) begin
          $error("sample_out expected %0d actual %0d", x.sample, out_sample_out);
          failures++;
        end
        if (out_gain_change_db !== x.gain) begin
          $error("gain_change_db expected %0d actual %0d", x.gain, out_gain_change_db);
          failures++;
        end
      end
    end
  end

  task automatic send_sample(logic signed [SW-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_sample_in <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_q.push_back(compress_sample(smp));
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIW-1:0] idx, longint val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CDW'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == adrc_pkg::REG_THRESHOLD) thr_q = longint'($signed(16'(val)));
    else if (idx == adrc_pkg::REG_INV_RATIO) inv_q = val & 17'h1FFFF;
    else if (idx == adrc_pkg::REG_SMOOTH) coeff_q = val & 16'hFFFF;
    @(posedge clk);
  endtask

  task automatic set_config(longint thr, longint inv, longint a);
    write_reg(adrc_pkg::REG_THRESHOLD, thr);
    write_reg(adrc_pkg::REG_INV_RATIO, inv);
    write_reg(adrc_pkg::REG_SMOOTH, a);
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(5))
      0: return SW'($urandom);
      1: return SW'($signed($urandom_range(64)) - 32);
      2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: return SW'($signed(32'($urandom_range(2 ** $urandom_range(15)))) *
                          ($urandom_range(1) ? 1 : -1));
    endcase
  endfunction

  task automatic test_directed();
    logic signed [SW-1:0] vals[] = '{16'sd0, 16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1,
      16'sd2, 16'sh4000, -16'sh4000, 16'sd255, 16'sd256, 16'sh5555, 16'shAAAA, 16'sd0};
    foreach (vals[i]) send_sample(vals[i]);
    // no smoothing at unity ratio, then positive threshold with inverse ratio above one
    set_config(-24576, 65536, 0);
    foreach (vals[i]) send_sample(vals[i]);
    set_config(1000, 131071, 65535);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sd3);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_sample(pick_sample());
  endtask

  task automatic test_settings();
    set_config(0, 0, 0);
    test_random(80);
    set_config(-24576, 65536, 65535);
    test_random(60);
    set_config(-2560, 8192, 40000);
    test_random(80);
  endtask

  task automatic test_backpressure();
    hold_reqs++;
    test_random(40);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_in = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 38;
    recv_idle_pct = 86;
    fill_tables();
    thr_q = -5120;
    inv_q = 16384;
    coeff_q = 65000;
    env_q = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    set_config(-5120, 16384, 65000);
    test_random(150);
    send_idle_pct = 86;
    recv_idle_pct = 38;
    test_settings();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    set_config($signed($urandom_range(24576)) * -1, $urandom_range(65536),
               $urandom_range(65535));
    test_random(300);
    drain();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/adrc_pkg.sv
sv/adrc_mul.sv
sv/adrc_log.sv
sv/audio_dynamic_range_compressor_top.sv
tb/sv/testbench.sv
